### src/wbps_pkg.sv
// Package for the wildcard byte pattern scanner.
// Holds field widths, configuration register codes and the result record.
// No dependencies.
package wbps_pkg;

  localparam int unsigned DATA_W       = 8;
  localparam int unsigned PATTERN_W    = 64;
  localparam int unsigned CARE_W       = 8;
  localparam int unsigned LEN_W        = 4;
  localparam int unsigned COUNT_W      = 16;
  localparam int unsigned OUT_OFFSET_W = 32;
  localparam int unsigned CFG_IDX_W    = 2;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES  = 2'd0,
    CFG_CARE_MASK      = 2'd1,
    CFG_PATTERN_LENGTH = 2'd2,
    CFG_MAX_MATCHES    = 2'd3
  } cfg_idx_t;

  // One result item as formed by the scan stage.
  typedef struct packed {
    logic                    hit;
    logic [OUT_OFFSET_W-1:0] hit_offset;
    logic [COUNT_W-1:0]      hits_so_far;
    logic                    scan_done;
  } scan_res_t;

endpackage

### src/wbps_match.sv
// Parallel window compare for the wildcard byte pattern scanner.
// Depends on wbps_pkg for field widths.
module wbps_match #(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned FILL_W      = 4
) (
  input  logic [PATTERN_MAX*wbps_pkg::DATA_W-1:0] window,
  input  logic [FILL_W-1:0]                       fill,
  input  logic [wbps_pkg::PATTERN_W-1:0]          pattern,
  input  logic [wbps_pkg::CARE_W-1:0]             care,
  input  logic [wbps_pkg::LEN_W-1:0]              len,
  output logic                                    match
);

  // For each possible length, entry 0 is the newest byte, so pattern byte j
  // lines up with window entry len-1-j.
  always_comb begin
    logic ok;
    match = 1'b0;
    for (int l = 1; l <= int'(PATTERN_MAX); l++) begin
      ok = 1'b1;
      for (int j = 0; j < l; j++) begin
        if (care[j] &&
            window[wbps_pkg::DATA_W*(l-1-j) +: wbps_pkg::DATA_W] !=
            pattern[wbps_pkg::DATA_W*j +: wbps_pkg::DATA_W]) begin
          ok = 1'b0;
        end
      end
      if (len == wbps_pkg::LEN_W'(l) && fill >= FILL_W'(l) && ok) begin
        match = 1'b1;
      end
    end
  end

endmodule

### src/wbps_scan.sv
// Scan state of the wildcard byte pattern scanner: byte window, fill,
// byte position and hit count, plus the result of the current byte.
// Depends on wbps_pkg and wbps_match.
module wbps_scan #(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step,
  input  logic [wbps_pkg::DATA_W-1:0]    data_byte,
  input  logic                           image_end,
  input  logic [wbps_pkg::PATTERN_W-1:0] pattern,
  input  logic [wbps_pkg::CARE_W-1:0]    care,
  input  logic [wbps_pkg::LEN_W-1:0]     len_cfg,
  input  logic [wbps_pkg::COUNT_W-1:0]   max_matches,
  output wbps_pkg::scan_res_t            res
);

  localparam int unsigned WIN_W  = PATTERN_MAX * wbps_pkg::DATA_W;
  localparam int unsigned FILL_W = $clog2(PATTERN_MAX + 1);

  logic [WIN_W-1:0]             window_r, window_nxt, window_sh;
  logic [FILL_W-1:0]            fill_r, fill_nxt, fill_sh;
  logic [OFFSET_BITS-1:0]       pos_r, pos_nxt, start_pos;
  logic [wbps_pkg::COUNT_W-1:0] count_r, count_nxt, count_upd;
  logic [wbps_pkg::LEN_W-1:0]   len_eff;
  logic                         match, hit;

  // Clamp the length to the window depth.
  assign len_eff = (len_cfg > wbps_pkg::LEN_W'(PATTERN_MAX)) ?
                   wbps_pkg::LEN_W'(PATTERN_MAX) : len_cfg;

  // Shift the new byte in at entry 0.
  generate
    if (PATTERN_MAX > 1) begin : g_shift
      assign window_sh = {window_r[WIN_W-wbps_pkg::DATA_W-1:0], data_byte};
    end else begin : g_single
      assign window_sh = data_byte;
    end
  endgenerate

  assign fill_sh = (fill_r < FILL_W'(PATTERN_MAX)) ? fill_r + FILL_W'(1) : fill_r;

  wbps_match #(
    .PATTERN_MAX (PATTERN_MAX),
    .FILL_W      (FILL_W)
  ) u_match (
    .window  (window_sh),
    .fill    (fill_sh),
    .pattern (pattern),
    .care    (care),
    .len     (len_eff),
    .match   (match)
  );

  assign hit       = match && (max_matches == '0 || count_r < max_matches);
  assign start_pos = pos_r + OFFSET_BITS'(1) - OFFSET_BITS'(len_eff);
  assign count_upd = (hit && count_r != wbps_pkg::COUNT_MAX) ?
                     count_r + wbps_pkg::COUNT_W'(1) : count_r;

  always_comb begin
    res.hit         = hit;
    res.hit_offset  = hit ? wbps_pkg::OUT_OFFSET_W'(start_pos) : '0;
    res.hits_so_far = count_upd;
    res.scan_done   = image_end;
  end

  // Clear all scan state after the image's last byte.
  always_comb begin
    window_nxt = window_r;
    fill_nxt   = fill_r;
    pos_nxt    = pos_r;
    count_nxt  = count_r;
    if (step) begin
      if (image_end) begin
        window_nxt = '0;
        fill_nxt   = '0;
        pos_nxt    = '0;
        count_nxt  = '0;
      end else begin
        window_nxt = window_sh;
        fill_nxt   = fill_sh;
        pos_nxt    = pos_r + OFFSET_BITS'(1);
        count_nxt  = count_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= '0;
      fill_r   <= '0;
      pos_r    <= '0;
      count_r  <= '0;
    end else begin
      window_r <= window_nxt;
      fill_r   <= fill_nxt;
      pos_r    <= pos_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

### src/wildcard_byte_pattern_scan.sv
// Wildcard byte pattern scanner, top level: configuration registers,
// scan stage and result register.
// Depends on wbps_pkg and wbps_scan.
//
// Takes one image byte per cycle and returns one result item per byte, in the
// cycle after the byte is accepted. The window compare against all pattern
// lengths is parallel logic between the scan state and the result register,
// so the sustained rate is one item per clock; in_stall rises only while a
// finished result sits in the result register and out_stall holds it. Each
// result tells whether the configured pattern (up to PATTERN_MAX bytes, a
// zero care bit makes that byte a wildcard) ends at this byte, the image
// offset of the pattern's first byte (offsets wrap at OFFSET_BITS), and the
// number of hits reported so far in the image. Once max_matches hits are
// reported (zero means no limit), further matches read as no hit. The byte
// flagged image_end gives scan_done and restarts window, offset and count
// for the next image. Write configuration only while the block is idle;
// cfg_ready is always high.
module wildcard_byte_pattern_scan #(
  parameter int unsigned PATTERN_MAX = 8,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wbps_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wbps_pkg::PATTERN_W-1:0]    cfg_wdata,
  // input item channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [wbps_pkg::DATA_W-1:0]       in_data_byte,
  input  logic                              in_image_end,
  // result item channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic [wbps_pkg::OUT_OFFSET_W-1:0] out_hit_offset,
  output logic [wbps_pkg::COUNT_W-1:0]      out_hits_so_far,
  output logic                              out_scan_done
);

  logic [wbps_pkg::PATTERN_W-1:0] pattern_r, pattern_nxt;
  logic [wbps_pkg::CARE_W-1:0]    care_r, care_nxt;
  logic [wbps_pkg::LEN_W-1:0]     len_r, len_nxt;
  logic [wbps_pkg::COUNT_W-1:0]   max_r, max_nxt;

  logic                           in_fire;
  logic                           out_valid_r, out_valid_nxt;
  wbps_pkg::scan_res_t            scan_res;
  wbps_pkg::scan_res_t            res_r;

  // ---------------------------------------------------------------------
  // Configuration registers: always ready, decode the index.
  // ---------------------------------------------------------------------
  assign cfg_ready = 1'b1;

  always_comb begin
    pattern_nxt = pattern_r;
    care_nxt    = care_r;
    len_nxt     = len_r;
    max_nxt     = max_r;
    if (cfg_valid && cfg_ready) begin
      unique case (wbps_pkg::cfg_idx_t'(cfg_index))
        wbps_pkg::CFG_PATTERN_BYTES:  pattern_nxt = cfg_wdata;
        wbps_pkg::CFG_CARE_MASK:      care_nxt    = cfg_wdata[wbps_pkg::CARE_W-1:0];
        wbps_pkg::CFG_PATTERN_LENGTH: len_nxt     = cfg_wdata[wbps_pkg::LEN_W-1:0];
        wbps_pkg::CFG_MAX_MATCHES:    max_nxt     = cfg_wdata[wbps_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pattern_r <= '0;
      care_r    <= {wbps_pkg::CARE_W{1'b1}};
      len_r     <= wbps_pkg::LEN_W'(8);
      max_r     <= '0;
    end else begin
      pattern_r <= pattern_nxt;
      care_r    <= care_nxt;
      len_r     <= len_nxt;
      max_r     <= max_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Scan stage: advance the state and form the result for each item.
  // Hold the input only while the result register cannot drain.
  // ---------------------------------------------------------------------
  assign in_stall = out_valid_r && out_stall;
  assign in_fire  = in_valid && !in_stall;

  wbps_scan #(
    .PATTERN_MAX (PATTERN_MAX),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_fire),
    .data_byte   (in_data_byte),
    .image_end   (in_image_end),
    .pattern     (pattern_r),
    .care        (care_r),
    .len_cfg     (len_r),
    .max_matches (max_r),
    .res         (scan_res)
  );

  // ---------------------------------------------------------------------
  // Result register: load on every accepted item, drop once taken.
  // ---------------------------------------------------------------------
  always_comb begin
    if (in_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= scan_res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = res_r.hit;
  assign out_hit_offset  = res_r.hit_offset;
  assign out_hits_so_far = res_r.hits_so_far;
  assign out_scan_done   = res_r.scan_done;

`ifndef SYNTHESIS
  // An accepted item always shows up in the result register next cycle.
  a_fire_loads_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted item did not reach the result register");

  // A reported hit is counted.
  a_hit_counted: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_hits_so_far != '0)
    else $error("hit reported with zero hit count");

  // A miss carries a zero offset.
  a_miss_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_hit_offset == '0)
    else $error("offset nonzero without a hit");

  // The result register holds while it is full and not taken.
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(res_r))
    else $error("result register changed while stalled");
`endif

endmodule
